[src/lssp_pkg.sv]
// ----------------------------------------------------------------------------
// lssp_pkg
// Shared types and constants of the link-state shortest path engine.
// ----------------------------------------------------------------------------
package lssp_pkg;

  localparam int NODE_W = 5;
  localparam int COST_W = 16;
  localparam int PATH_W = 21;
  localparam logic [PATH_W-1:0] PATH_MAX = {PATH_W{1'b1}};

  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_CMP_INIT,
    ST_CMP_PASS,
    ST_Q_RD,
    ST_Q_FIRST,
    ST_Q_WALK,
    ST_Q_LOAD,
    ST_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic cfg_ack;
    logic capture;
    logic upd_rd;
    logic upd_wr;
    logic cmp_init;
    logic pass_step;
    logic pass_end;
    logic q_rd;
    logic q_first;
    logic q_issue;
    logic q_load;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic cfg_pend;
    logic self_ok;
    logic pass_done;
    logic found;
    logic q_route;
    logic walk_done;
    logic out_free;
  } stat_t;

endpackage

[src/lssp_if.sv]
// ----------------------------------------------------------------------------
// lssp_in_if / lssp_out_if
// Valid/ready channels carrying update/query items and their results.
// ----------------------------------------------------------------------------
interface lssp_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [4:0]  src_node;
  logic [4:0]  dst_node;
  logic [15:0] link_cost;

  modport source (output valid, func, src_node, dst_node, link_cost, input ready);
  modport sink   (input valid, func, src_node, dst_node, link_cost, output ready);
endinterface

interface lssp_out_if;
  logic        valid;
  logic        ready;
  logic        changed;
  logic        reachable;
  logic [4:0]  next_hop;
  logic [20:0] path_cost;

  modport source (output valid, changed, reachable, next_hop, path_cost, input ready);
  modport sink   (input valid, changed, reachable, next_hop, path_cost, output ready);
endinterface

[src/link_state_shortest_path_core.sv]
// ----------------------------------------------------------------------------
// link_state_shortest_path_core
// Link-state routing engine: link cost matrix plus shortest path routes.
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one item per transaction: func 0 writes link
//   src_node -> dst_node with link_cost and recomputes all routes from the
//   self node; func 1 queries the route to dst_node
//   out_ch returns exactly one result per item: changed for updates,
//   reachable / next_hop / path_cost for queries
//   cfg_* is an apb-style port holding self_node at byte address 0; a write
//   recomputes the routes before the next item is taken
// operation
//   update: one pass over the link matrix row (one link memory read a
//   cycle) is made per finalized node, the self node included
//   query: a predecessor walk through node memory
//   one item is in work at a time; a new item is taken while a finished
//   result still waits in the output register
// reset
//   a clearing pass over all 2^(2*clog2(NODES)) entries (1024 at 32 nodes)
//   wipes the link matrix; in_ch.ready stays low meanwhile
// stall
//   a result held by out_ch.ready low stalls the engine in ST_RESULT with the next result
// ----------------------------------------------------------------------------
module link_state_shortest_path_core
  import lssp_pkg::*;
#(
  parameter int NODES = 32
)
(
  input  logic        clk,
  input  logic        rst_n,
  lssp_in_if.sink     in_ch,
  lssp_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic CFG_IDX_SELF = 1'b0;

  cmd_t              cmd;
  stat_t             stat;
  logic              cfg_wr;
  logic [NODE_W-1:0] self_node;

  // apb access: no wait states, one register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == CFG_IDX_SELF);
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_SELF) ? {{(32-NODE_W){1'b0}}, self_node} : '0;

  lssp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lssp_dp #(.NODES(NODES)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_wr),
    .cfg_wdata     (cfg_pwdata[NODE_W-1:0]),
    .cfg_self      (self_node),
    .in_func       (in_ch.func),
    .in_src_node   (in_ch.src_node),
    .in_dst_node   (in_ch.dst_node),
    .in_link_cost  (in_ch.link_cost),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_changed   (out_ch.changed),
    .out_reachable (out_ch.reachable),
    .out_next_hop  (out_ch.next_hop),
    .out_path_cost (out_ch.path_cost)
  );

  // after an accepted item the engine is busy and in_ch.ready goes low
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("item accepted while engine still busy");

  // no items and no results while the link matrix is being cleared
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.clr_done |-> !in_ch.ready && !out_ch.valid)
    else $error("traffic during clearing pass");

  // a self node write holds off items until routes are recomputed
  a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> !in_ch.ready)
    else $error("item taken before recompute after self node write");

  // a new result is loaded only when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.path_cost))
    else $error("waiting result overwritten");

endmodule

[src/lssp_ctrl.sv]
// ----------------------------------------------------------------------------
// lssp_ctrl
// Sequencer: clearing pass, update, route recompute passes, query walk.
// ----------------------------------------------------------------------------
module lssp_ctrl
  import lssp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_func,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   from_cfg_r, from_cfg_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      from_cfg_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      from_cfg_r <= from_cfg_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    from_cfg_nxt = from_cfg_r;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        if (stat.clr_done) state_nxt = ST_IDLE;
        else cmd.clr_step = 1'b1;
      end
      ST_IDLE: begin
        if (stat.cfg_pend) begin
          cmd.cfg_ack  = 1'b1;
          from_cfg_nxt = 1'b1;
          state_nxt    = ST_CMP_INIT;
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.capture  = 1'b1;
            from_cfg_nxt = 1'b0;
            state_nxt    = (in_func == FUNC_QUERY) ? ST_Q_RD : ST_UPD_RD;
          end
        end
      end
      ST_UPD_RD: begin
        cmd.upd_rd = 1'b1;
        state_nxt  = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        cmd.upd_wr = 1'b1;
        state_nxt  = ST_CMP_INIT;
      end
      ST_CMP_INIT: begin
        cmd.cmp_init = 1'b1;
        if (stat.self_ok) state_nxt = ST_CMP_PASS;
        else state_nxt = from_cfg_r ? ST_IDLE : ST_RESULT;
      end
      ST_CMP_PASS: begin
        if (!stat.pass_done) begin
          cmd.pass_step = 1'b1;
        end else begin
          cmd.pass_end = 1'b1;
          if (!stat.found) state_nxt = from_cfg_r ? ST_IDLE : ST_RESULT;
        end
      end
      ST_Q_RD: begin
        cmd.q_rd  = 1'b1;
        state_nxt = stat.q_route ? ST_Q_FIRST : ST_RESULT;
      end
      ST_Q_FIRST: begin
        cmd.q_first = 1'b1;
        state_nxt   = ST_Q_WALK;
      end
      ST_Q_WALK: begin
        if (stat.walk_done) begin
          state_nxt = ST_RESULT;
        end else begin
          cmd.q_issue = 1'b1;
          state_nxt   = ST_Q_LOAD;
        end
      end
      ST_Q_LOAD: begin
        cmd.q_load = 1'b1;
        state_nxt  = ST_Q_WALK;
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

endmodule

[src/lssp_dp.sv]
// ----------------------------------------------------------------------------
// lssp_dp
// Link matrix memory, node distance/predecessor memory, scan pipeline,
// predecessor walk and the result register.
// ----------------------------------------------------------------------------
module lssp_dp
  import lssp_pkg::*;
#(
  parameter int NODES = 32
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic              cfg_we,
  input  logic [NODE_W-1:0] cfg_wdata,
  output logic [NODE_W-1:0] cfg_self,
  input  logic              in_func,
  input  logic [NODE_W-1:0] in_src_node,
  input  logic [NODE_W-1:0] in_dst_node,
  input  logic [COST_W-1:0] in_link_cost,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_changed,
  output logic              out_reachable,
  output logic [NODE_W-1:0] out_next_hop,
  output logic [PATH_W-1:0] out_path_cost
);

  localparam int NW   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LW   = 2 * NW;
  localparam int LDEP = 1 << LW;
  localparam int DW   = COST_W + NW;
  localparam int LMW  = COST_W + 1;
  localparam int NMW  = DW + NW;

  // memories
  logic [LMW-1:0] link_mem [0:LDEP-1];
  logic [NMW-1:0] node_mem [0:NODES-1];
  logic [LMW-1:0] lm_rdata_r;
  logic [NMW-1:0] nm_rdata_r;
  logic [LW-1:0]  lm_raddr, lm_waddr;
  logic [LMW-1:0] lm_wdata;
  logic           lm_we;
  logic [NW-1:0]  nm_raddr;
  logic           nm_we;
  logic [NMW-1:0] nm_wdata;

  // configuration
  logic [NODE_W-1:0] self_r;
  logic              pend_r;
  logic [NW-1:0]     self_idx;
  logic              self_ok;

  // captured item
  logic              func_r;
  logic [NODE_W-1:0] src_r, dst_r;
  logic [COST_W-1:0] cost_r;
  logic [NW-1:0]     src_idx, dst_idx;
  logic              src_ok, dst_ok;

  // node flags
  logic [NODES-1:0] known_r, tent_r, fin_r, rv_r;

  // scan pipeline
  logic [LW:0]   clr_cnt_r;
  logic [NW:0]   j_r;
  logic          pv_r;
  logic [NW-1:0] pj_r;
  logic [NW-1:0] cur_r, best_r;
  logic [DW-1:0] dcur_r, bestd_r;
  logic          found_r;

  // query walk
  logic          qok_r, chg_r;
  logic [NW-1:0] hop_r, n_r;
  logic [NW:0]   steps_r;
  logic [DW-1:0] qd_r;

  // output register
  logic              ov_r;
  logic              oc_r, orch_r;
  logic [NODE_W-1:0] oh_r;
  logic [PATH_W-1:0] op_r;

  // scan stage signals
  logic          s_pres, s_relax, s_cand;
  logic [DW-1:0] s_nd, s_dold, s_newd;
  logic          j_live;

  assign self_idx = NW'(self_r);
  assign self_ok  = 32'(self_r) < 32'(NODES);
  assign src_idx  = NW'(src_r);
  assign dst_idx  = NW'(dst_r);
  assign src_ok   = 32'(src_r) < 32'(NODES);
  assign dst_ok   = 32'(dst_r) < 32'(NODES);
  assign j_live   = 32'(j_r) < 32'(NODES);
  assign cfg_self = self_r;

  // relax and minimum search on the element read in the previous cycle
  assign s_pres = lm_rdata_r[COST_W];
  assign s_dold = nm_rdata_r[NMW-1:NW];
  assign s_nd   = dcur_r + DW'(lm_rdata_r[COST_W-1:0]);
  assign s_relax = pv_r && s_pres && !fin_r[pj_r] && (!tent_r[pj_r] || s_dold > s_nd);
  assign s_newd  = s_relax ? s_nd : s_dold;
  assign s_cand  = pv_r && known_r[pj_r] && (tent_r[pj_r] || s_relax) && !fin_r[pj_r]
                   && (!found_r || s_newd < bestd_r);

  // memory ports
  always_comb begin
    lm_raddr = cmd.upd_rd ? {src_idx, dst_idx} : {cur_r, j_r[NW-1:0]};
    lm_we    = cmd.clr_step || (cmd.upd_wr && src_ok && dst_ok);
    lm_waddr = cmd.clr_step ? clr_cnt_r[LW-1:0] : {src_idx, dst_idx};
    lm_wdata = cmd.clr_step ? '0 : {1'b1, cost_r};
    if (cmd.q_rd) nm_raddr = dst_idx;
    else if (cmd.q_issue) nm_raddr = n_r;
    else nm_raddr = j_r[NW-1:0];
    nm_we    = s_relax;
    nm_wdata = {s_nd, cur_r};
  end

  always_ff @(posedge clk) begin
    if (lm_we) link_mem[lm_waddr] <= lm_wdata;
    lm_rdata_r <= link_mem[lm_raddr];
  end

  always_ff @(posedge clk) begin
    if (nm_we) node_mem[pj_r] <= nm_wdata;
    nm_rdata_r <= node_mem[nm_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_r    <= '0;
      pend_r    <= 1'b0;
      clr_cnt_r <= '0;
      known_r   <= '0;
      tent_r    <= '0;
      fin_r     <= '0;
      rv_r      <= '0;
      pv_r      <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        self_r <= cfg_wdata;
        pend_r <= 1'b1;
      end else if (cmd.cfg_ack) begin
        pend_r <= 1'b0;
      end
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + (LW+1)'(1);
      if (cmd.upd_wr && src_ok && dst_ok)
        known_r <= known_r | (NODES'(1) << src_idx) | (NODES'(1) << dst_idx);
      if (cmd.cmp_init) begin
        tent_r <= '0;
        rv_r   <= '0;
        fin_r  <= self_ok ? (NODES'(1) << self_idx) : '0;
      end else begin
        if (s_relax) tent_r[pj_r] <= 1'b1;
        if (cmd.pass_end && found_r) begin
          fin_r[best_r] <= 1'b1;
          rv_r[best_r]  <= 1'b1;
        end
      end
      pv_r <= cmd.pass_step && j_live;
      if (cmd.out_load) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      src_r  <= in_src_node;
      dst_r  <= in_dst_node;
      cost_r <= in_link_cost;
      chg_r  <= 1'b0;
      qok_r  <= 1'b0;
    end
    if (cmd.upd_wr)
      chg_r <= src_ok && dst_ok &&
               (!lm_rdata_r[COST_W] || lm_rdata_r[COST_W-1:0] != cost_r);
    if (cmd.cmp_init) begin
      cur_r   <= self_idx;
      dcur_r  <= '0;
      j_r     <= '0;
      found_r <= 1'b0;
    end else begin
      if (cmd.pass_step && j_live) j_r <= j_r + (NW+1)'(1);
      if (s_cand) begin
        found_r <= 1'b1;
        best_r  <= pj_r;
        bestd_r <= s_newd;
      end
      if (cmd.pass_end && found_r) begin
        cur_r   <= best_r;
        dcur_r  <= bestd_r;
        j_r     <= '0;
        found_r <= 1'b0;
      end
    end
    pj_r <= j_r[NW-1:0];
    if (cmd.q_rd) qok_r <= stat.q_route;
    if (cmd.q_first) begin
      qd_r    <= nm_rdata_r[NMW-1:NW];
      n_r     <= nm_rdata_r[NW-1:0];
      hop_r   <= dst_idx;
      steps_r <= '0;
    end
    if (cmd.q_issue) begin
      hop_r   <= n_r;
      steps_r <= steps_r + (NW+1)'(1);
    end
    if (cmd.q_load) n_r <= nm_rdata_r[NW-1:0];
    if (cmd.out_load) begin
      oc_r   <= (func_r == FUNC_UPDATE) && chg_r;
      orch_r <= (func_r == FUNC_QUERY) && qok_r;
      oh_r   <= ((func_r == FUNC_QUERY) && qok_r) ? NODE_W'(hop_r) : '0;
      if ((func_r == FUNC_QUERY) && qok_r)
        op_r <= (32'(qd_r) > 32'(PATH_MAX)) ? PATH_MAX : PATH_W'(qd_r);
      else
        op_r <= '0;
    end
  end

  always_comb begin
    stat.clr_done  = clr_cnt_r[LW];
    stat.cfg_pend  = pend_r;
    stat.self_ok   = self_ok;
    stat.pass_done = !j_live && !pv_r;
    stat.found     = found_r;
    stat.q_route   = dst_ok && rv_r[dst_idx];
    stat.walk_done = (n_r == self_idx) || (32'(steps_r) == 32'(NODES));
    stat.out_free  = !ov_r || out_ready;
  end

  assign out_valid     = ov_r;
  assign out_changed   = oc_r;
  assign out_reachable = orch_r;
  assign out_next_hop  = oh_r;
  assign out_path_cost = op_r;

endmodule

[dv/lssp_route_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lssp_route_checker
// Watches both channels and the register port, keeps its own copy of the
// link matrix and routes, and checks every result against its prediction.
// ----------------------------------------------------------------------------
module lssp_route_checker
  import lssp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lssp_in_if.sink     in_mon,
  lssp_out_if.sink    out_mon,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending_count,
  output int          query_count,
  output int          route_hits
);

  localparam int N = 32;
  localparam logic [2:0] ADDR_SELF = 3'd0;

  typedef struct packed {
    logic              changed;
    logic              reachable;
    logic [NODE_W-1:0] next_hop;
    logic [PATH_W-1:0] path_cost;
  } route_res_t;

  logic [NODE_W-1:0] my_node;
  logic              has_link [N*N];
  logic [COST_W-1:0] weight   [N*N];
  logic              seen     [N];
  int unsigned       best_dist [N];
  logic [NODE_W-1:0] prev     [N];
  logic              routed   [N];
  route_res_t        expected_q[$];

  // dijkstra from my_node, lowest number wins ties
  function automatic void solve_routes();
    logic tent [N];
    logic done [N];
    int cur, bst;
    int unsigned dcur, nd, bd;
    logic fnd;
    for (int j = 0; j < N; j++) begin
      tent[j] = 0; done[j] = 0; best_dist[j] = 0; prev[j] = '0; routed[j] = 0;
    end
    cur = my_node;
    dcur = 0;
    done[cur] = 1;
    forever begin
      for (int j = 0; j < N; j++) begin
        if (has_link[cur*N+j] && !done[j]) begin
          nd = dcur + weight[cur*N+j];
          if (!tent[j] || best_dist[j] > nd) begin
            tent[j] = 1; best_dist[j] = nd; prev[j] = cur[NODE_W-1:0];
          end
        end
      end
      fnd = 0; bst = 0; bd = 0;
      for (int j = 0; j < N; j++) begin
        if (seen[j] && tent[j] && !done[j] && (!fnd || best_dist[j] < bd)) begin
          fnd = 1; bst = j; bd = best_dist[j];
        end
      end
      if (!fnd) break;
      done[bst] = 1;
      routed[bst] = 1;
      cur = bst;
      dcur = bd;
    end
  endfunction

  function automatic route_res_t predict_item(logic fn, logic [4:0] s, logic [4:0] d,
                                              logic [15:0] c);
    route_res_t r;
    int hop, n, steps;
    r = '0;
    if (fn == FUNC_UPDATE) begin
      r.changed = !has_link[s*N+d] || weight[s*N+d] != c;
      has_link[s*N+d] = 1;
      weight[s*N+d] = c;
      seen[s] = 1;
      seen[d] = 1;
      solve_routes();
    end else if (routed[d]) begin
      hop = d; n = prev[d]; steps = 0;
      while (n != my_node && steps < N) begin
        hop = n; n = prev[n]; steps++;
      end
      r.reachable = 1;
      r.next_hop = hop[NODE_W-1:0];
      r.path_cost = (best_dist[d] > PATH_MAX) ? PATH_MAX : best_dist[d][PATH_W-1:0];
    end
    return r;
  endfunction

  assign pending_count = expected_q.size();

  always @(posedge clk) begin
    route_res_t got, exp_r;
    if (!rst_n) begin
      for (int i = 0; i < N*N; i++) has_link[i] = 0;
      for (int i = 0; i < N; i++) begin
        seen[i] = 0; routed[i] = 0; prev[i] = '0; best_dist[i] = 0;
      end
      my_node = '0;
      expected_q.delete();
      fail_count <= 0;
      query_count <= 0;
      route_hits <= 0;
    end else begin
      // register write recomputes routes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == ADDR_SELF[2]) begin
        my_node = cfg_pwdata[NODE_W-1:0];
        solve_routes();
      end
      // result side first: a result can't belong to an item taken this edge
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.changed, out_mon.reachable, out_mon.next_hop, out_mon.path_cost};
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transaction %p", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            if (fail_count < 10)
              $display("result mismatch: expected %p, got %p", exp_r, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        exp_r = predict_item(in_mon.func, in_mon.src_node, in_mon.dst_node,
                             in_mon.link_cost);
        if (in_mon.func == FUNC_QUERY) begin
          query_count <= query_count + 1;
          if (exp_r.reachable) route_hits <= route_hits + 1;
        end
        expected_q.push_back(exp_r);
      end
    end
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives link updates and route queries into the routing engine with random
// bursts and stalls, moves the self node between phases, and reports the
// verdict from the route checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
  import lssp_pkg::*;

  localparam int  RAND_ITEMS = 520;
  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam logic [2:0] ADDR_SELF = 3'd0;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count, pending_count, query_count, route_hits;
  longint      cycle_count = 0;
  int          item_count = 0;
  // a small working set of nodes so random links build real topologies
  logic [4:0]  node_pool [8];

  lssp_in_if  in_ch ();
  lssp_out_if out_ch ();

  link_state_shortest_path_core i_dut (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  lssp_route_checker i_checker (
    .clk, .rst_n, .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .fail_count, .pending_count, .query_count, .route_hits
  );

  always #1 clk = ~clk;

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("link_state_shortest_path_core: mismatch");
      $finish;
    end
  end

  // receiver stall pattern: runs of ready, runs of stall, some long open stretches
  initial begin
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      case ($urandom_range(0, 3))
        0: out_ch.ready <= 1'b0;
        default: out_ch.ready <= 1'b1;
      endcase
      repeat ($urandom_range(0, 6)) @(posedge clk);
    end
  end

  initial begin
    in_ch.valid = 0;
    in_ch.func = FUNC_UPDATE;
    in_ch.src_node = '0;
    in_ch.dst_node = '0;
    in_ch.link_cost = '0;
  end

  // one transaction on the input channel; valid stays up through a burst
  task automatic send_item(logic fn, logic [4:0] s, logic [4:0] d, logic [15:0] c,
                           bit hold);
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.src_node <= s;
    in_ch.dst_node <= d;
    in_ch.link_cost <= c;
    do @(posedge clk); while (!in_ch.ready);
    item_count++;
    if (!hold) in_ch.valid <= 1'b0;
  endtask

  // apb setup + access, only when the engine is idle
  task automatic write_self(logic [4:0] node);
    while (pending_count != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= ADDR_SELF; cfg_pwdata <= ($urandom & 32'hFFFF_FFE0) | {27'b0, node};
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic random_phase(int count);
    logic fn;
    logic [4:0] s, d;
    logic [15:0] c;
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && count > 0) begin
        fn = ($urandom_range(0, 9) < 4) ? FUNC_UPDATE : FUNC_QUERY;
        s = ($urandom_range(0, 9) < 8) ? node_pool[$urandom_range(0, 7)] : 5'($urandom);
        d = ($urandom_range(0, 9) < 8) ? node_pool[$urandom_range(0, 7)] : 5'($urandom);
        // mostly small costs so ties and detours happen, sometimes extremes
        case ($urandom_range(0, 5))
          0: c = 16'($urandom);
          1: c = 16'hFFFF;
          default: c = 16'($urandom_range(0, 12));
        endcase
        burst--; count--;
        send_item(fn, s, d, c, burst > 0 && count > 0);
      end
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) node_pool[i] = 5'($urandom);
    node_pool[0] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty table, extremes, equal-cost tie, unchanged rewrite
    send_item(FUNC_QUERY, 0, 5, 0, 0);
    send_item(FUNC_UPDATE, 0, 1, 16'd0, 0);
    send_item(FUNC_UPDATE, 0, 1, 16'd0, 0);
    send_item(FUNC_UPDATE, 1, 31, 16'hFFFF, 1);
    send_item(FUNC_UPDATE, 0, 2, 16'd5, 1);
    send_item(FUNC_UPDATE, 2, 3, 16'd5, 1);
    send_item(FUNC_UPDATE, 0, 3, 16'd10, 0);
    send_item(FUNC_QUERY, 0, 3, 0, 1);
    send_item(FUNC_QUERY, 31, 31, 16'hFFFF, 1);
    send_item(FUNC_QUERY, 0, 0, 0, 0);
    send_item(FUNC_UPDATE, 31, 30, 16'hFFFF, 0);
    send_item(FUNC_UPDATE, 0, 3, 16'd3, 0);
    send_item(FUNC_QUERY, 0, 3, 0, 0);
    send_item(FUNC_QUERY, 0, 30, 0, 0);
    send_item(FUNC_QUERY, 0, 17, 0, 0);

    // self node moves through extremes, a fixed node and a random pick between phases
    write_self(5'd31);
    send_item(FUNC_QUERY, 0, 30, 0, 0);
    send_item(FUNC_QUERY, 0, 0, 0, 0);
    write_self(5'd3);
    random_phase(RAND_ITEMS / 4);
    write_self(node_pool[$urandom_range(1, 7)]);
    random_phase(RAND_ITEMS / 4);
    write_self(5'd0);
    random_phase(RAND_ITEMS / 4);
    write_self(5'd31);
    random_phase(RAND_ITEMS / 4);

    while (pending_count != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    $display("sent %0d transactions, %0d queries of which %0d found a route",
             item_count, query_count, route_hits);
    if (fail_count == 0) begin
      $display("link_state_shortest_path_core: match");
    end else begin
      $display("link_state_shortest_path_core: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
src/lssp_pkg.sv
src/lssp_if.sv
src/lssp_ctrl.sv
src/lssp_dp.sv
src/link_state_shortest_path_core.sv
dv/lssp_route_checker.sv
dv/testbench.sv
